@@ rtl/jvps_pkg.sv @@
// Package with types, tables and constants of the jet valve pattern sequencer.
package jvps_pkg;

  localparam int unsigned ValveCount = 13;
  localparam int unsigned BandCount  = 7;

  localparam logic [2:0] ANIM_ROT_ONE = 3'd4;
  localparam logic [2:0] ANIM_INVALID = 3'd7;

  localparam logic [2:0] REG_RISE   = 3'd0;
  localparam logic [2:0] REG_FALL   = 3'd1;
  localparam logic [2:0] REG_PERIOD = 3'd2;
  localparam logic [2:0] REG_ANIM   = 3'd3;
  localparam logic [2:0] REG_BACK   = 3'd4;
  localparam logic [2:0] REG_GATE   = 3'd5;

  localparam logic [1:0] GATE_NONE   = 2'd0;
  localparam logic [1:0] GATE_BASS   = 2'd1;
  localparam logic [1:0] GATE_VOLUME = 2'd2;
  localparam logic [1:0] GATE_EITHER = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LAUNCH,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // Valve record held in memory: open flag, height, target.
  typedef struct packed {
    logic       is_open;
    logic [7:0] height;
    logic [7:0] target;
  } valve_t;

  function automatic logic [3:0] step_count(input logic [2:0] anim);
    return (anim >= ANIM_ROT_ONE) ? 4'd13 : 4'd2;
  endfunction

  function automatic logic [12:0] row_mask(input logic [2:0] anim, input logic [3:0] idx);
    logic [12:0] m;
    m = 13'h0000;
    unique case (anim)
      3'd0: m = idx[0] ? 13'h0AAA : 13'h1555;
      3'd1: m = idx[0] ? 13'h064C : 13'h19B3;
      3'd2: m = idx[0] ? 13'h03F8 : 13'h1C07;
      3'd3: m = idx[0] ? 13'h01F0 : 13'h1E0F;
      3'd4: m = (idx < 4'd13) ? (13'h0001 << idx) : 13'h0001 << (idx - 4'd13);
      3'd5: begin
        unique case (idx)
          4'd0: m = 13'h0003;  4'd1: m = 13'h000C;  4'd2: m = 13'h0030;
          4'd3: m = 13'h00C8;  4'd4: m = 13'h0300;  4'd5: m = 13'h0C00;
          4'd6: m = 13'h1001;  4'd7: m = 13'h0006;  4'd8: m = 13'h0018;
          4'd9: m = 13'h0060;  4'd10: m = 13'h0180; 4'd11: m = 13'h0600;
          4'd12: m = 13'h1800; 4'd13: m = 13'h0003; 4'd14: m = 13'h000C;
          default: m = 13'h0030;
        endcase
      end
      3'd6: begin
        unique case (idx)
          4'd0, 4'd12, 4'd13: m = 13'h1001;
          4'd1, 4'd11, 4'd14: m = 13'h0802;
          4'd2, 4'd10, 4'd15: m = 13'h0404;
          4'd3, 4'd9:  m = 13'h0208;
          4'd4, 4'd8:  m = 13'h0110;
          4'd5, 4'd7:  m = 13'h00A0;
          default:     m = 13'h0040;
        endcase
      end
      default: m = 13'h0000;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/jet_valve_pattern_sequencer.sv @@
// Top level of the jet valve pattern sequencer.
// Valve state lives in a 13-entry RAM, cleared by a pass over every entry after reset.
// A tick may skip both the launch check and the update; the launch check walks
// the RAM once, and a launch rewrites the armed entries in a second walk.
// An update emits one result per valve and can be held by output stalls.
// One tick at a time, taken once the last result has left the output; sync active-low reset.
module jet_valve_pattern_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // bass_beat[0], volume_beat[1], band_peak_0..6 [9:2]..[57:50], zero pad to 64
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // valve_index[3:0], valve_is_open[4], jet_level[12:5], jet_goal[20:13], pad
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import jvps_pkg::*;

  state_t       state_r, state_nxt;
  logic [7:0]   rise_r, fall_r;
  logic [15:0]  period_r;
  logic [2:0]   anim_r;
  logic         back_r;
  logic [1:0]   gate_r;
  logic [12:0]  pend_r, pend_nxt;
  logic [3:0]   pidx_r, pidx_nxt;
  logic [15:0]  elapsed_r, elapsed_nxt;
  logic [3:0]   vi_r, vi_nxt;
  logic         rd_ph_r, rd_ph_nxt;
  logic         clr_r, clr_nxt;
  logic         ok_r, ok_nxt;
  logic         bass_r, vol_r;
  logic [7:0]   peak_r [BandCount];
  logic         ov_r, ov_nxt;
  logic [23:0]  od_r, od_nxt;
  logic         ol_r, ol_nxt;

  logic         we;
  valve_t       wd, rd;
  logic [3:0]   ra;

  jvps_ram #(.WIDTH($bits(valve_t)), .DEPTH(ValveCount)) u_ram (
    .clk(clk), .wr_en(we), .wr_addr(vi_r), .wr_data(wd),
    .rd_addr(ra), .rd_data(rd)
  );

  assign in_tready  = (state_r == ST_IDLE) && !clr_r && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  logic        beat_ok, accepted;
  logic [2:0]  band;
  logic [7:0]  pa, pb;
  logic [8:0]  sum9, rise9;
  logic [3:0]  steps, nidx;
  logic [7:0]  fall_h;

  always_comb begin
    band     = vi_r[3:1];
    pa       = peak_r[band];
    pb       = (band == 3'd6) ? peak_r[0] : peak_r[band + 3'd1];
    sum9     = {1'b0, pa} + {1'b0, pb};
    rise9    = {1'b0, rd.height} + {1'b0, rise_r};
    fall_h   = (rd.height > fall_r) ? rd.height - fall_r : 8'd0;
    steps    = step_count(anim_r);
    if (!back_r) begin
      nidx = (pidx_r + 4'd1 >= steps || pidx_r == 4'd15) ? 4'd0 : pidx_r + 4'd1;
    end else begin
      nidx = (pidx_r == 4'd0 || pidx_r > steps) ? steps - 4'd1 : pidx_r - 4'd1;
    end
    unique case (gate_r)
      GATE_NONE:   beat_ok = 1'b1;
      GATE_BASS:   beat_ok = bass_r;
      GATE_VOLUME: beat_ok = vol_r;
      GATE_EITHER: beat_ok = bass_r | vol_r;
      default:     beat_ok = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    pend_nxt    = pend_r;
    pidx_nxt    = pidx_r;
    elapsed_nxt = elapsed_r;
    vi_nxt      = vi_r;
    rd_ph_nxt   = rd_ph_r;
    clr_nxt     = clr_r;
    ok_nxt      = ok_r;
    ov_nxt      = ov_r;
    od_nxt      = od_r;
    ol_nxt      = ol_r;
    accepted    = 1'b0;
    we          = 1'b0;
    wd          = rd;
    ra          = vi_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (clr_r) begin
          we = 1'b1;
          wd = '0;
          vi_nxt = vi_r + 4'd1;
          if (vi_r == 4'(ValveCount - 1)) begin
            clr_nxt = 1'b0;
            vi_nxt  = 4'd0;
          end
        end else if (in_tvalid && in_tready) begin
          accepted    = 1'b1;
          elapsed_nxt = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
          vi_nxt      = 4'd0;
          rd_ph_nxt   = 1'b0;
          ok_nxt      = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!(elapsed_r > period_r || bass_r || vol_r) || !beat_ok) begin
          state_nxt = ST_UPDATE;
          vi_nxt    = 4'd0;
          rd_ph_nxt = 1'b0;
        end else if (!rd_ph_r) begin
          rd_ph_nxt = 1'b1;
        end else begin
          if (pend_r[vi_r] && (rd.is_open || rd.height > {1'b0, rd.target[7:1]})) begin
            ok_nxt = 1'b0;
          end
          rd_ph_nxt = 1'b0;
          vi_nxt    = vi_r + 4'd1;
          if (vi_r == 4'(ValveCount - 1)) begin
            vi_nxt    = 4'd0;
            state_nxt = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH: begin
        if (!ok_r) begin
          state_nxt = ST_UPDATE;
        end else if (!rd_ph_r) begin
          rd_ph_nxt = 1'b1;
        end else begin
          we         = pend_r[vi_r];
          wd.is_open = 1'b1;
          wd.target  = vi_r[0] ? sum9[8:1] : pa;
          rd_ph_nxt  = 1'b0;
          vi_nxt     = vi_r + 4'd1;
          if (vi_r == 4'(ValveCount - 1)) begin
            vi_nxt    = 4'd0;
            state_nxt = ST_UPDATE;
            if (anim_r != ANIM_INVALID) begin
              pidx_nxt = nidx;
              pend_nxt = row_mask(anim_r, nidx);
            end
          end
        end
      end
      ST_UPDATE: begin
        if (elapsed_r < period_r) begin
          state_nxt = ST_IDLE;
        end else if (!rd_ph_r) begin
          rd_ph_nxt = 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_r || out_tready) begin
          we = 1'b1;
          if (rd.is_open) begin
            wd.height  = rise9[8] ? 8'hFF : rise9[7:0];
            wd.is_open = !((rise9[8] ? 8'hFF : rise9[7:0]) >= rd.target);
          end else begin
            wd.height = fall_h;
          end
          ov_nxt = 1'b1;
          od_nxt = {3'b000, rd.target, wd.height, wd.is_open, vi_r};
          ol_nxt = (vi_r == 4'(ValveCount - 1));
          rd_ph_nxt = 1'b0;
          vi_nxt    = vi_r + 4'd1;
          state_nxt = ST_UPDATE;
          if (vi_r == 4'(ValveCount - 1)) begin
            vi_nxt      = 4'd0;
            elapsed_nxt = 16'd0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rise_r    <= 8'd40;
      fall_r    <= 8'd20;
      period_r  <= 16'd100;
      anim_r    <= 3'd0;
      back_r    <= 1'b0;
      gate_r    <= GATE_NONE;
      pend_r    <= '0;
      pidx_r    <= '0;
      elapsed_r <= '0;
      vi_r      <= '0;
      rd_ph_r   <= 1'b0;
      clr_r     <= 1'b1;
      ok_r      <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pend_r    <= pend_nxt;
      pidx_r    <= pidx_nxt;
      elapsed_r <= elapsed_nxt;
      vi_r      <= vi_nxt;
      rd_ph_r   <= rd_ph_nxt;
      clr_r     <= clr_nxt;
      ok_r      <= ok_nxt;
      ov_r      <= ov_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_RISE:   rise_r   <= cfg_data[7:0];
          REG_FALL:   fall_r   <= cfg_data[7:0];
          REG_PERIOD: period_r <= cfg_data;
          REG_ANIM:   anim_r   <= cfg_data[2:0];
          REG_BACK:   back_r   <= cfg_data[0];
          REG_GATE:   gate_r   <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    ol_r <= ol_nxt;
    if (accepted) begin
      bass_r <= in_tdata[0];
      vol_r  <= in_tdata[1];
      for (int b = 0; b < BandCount; b++) begin
        peak_r[b] <= in_tdata[2 + 8*b +: 8];
      end
    end
  end

endmodule

@@ rtl/jvps_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read data.
module jvps_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 13
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

@@ rtl/jvps_checker.sv @@
// Port-level checker for the jet valve pattern sequencer, bound to the top level.
module jvps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed.");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[3:0] == 4'd12)))
    else $error("Last marker does not match valve twelve.");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= 4'd12)
    else $error("Valve index out of range.");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("Input taken while a result waits.");

endmodule

bind jet_valve_pattern_sequencer jvps_checker u_jvps_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);

@@ test/tb_checker.sv @@
// Checker that predicts and compares the valve results of the jet valve pattern sequencer.
`timescale 1ns / 1ps
module tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import jvps_pkg::*;

  typedef struct {
    logic [3:0] index;
    logic       is_open;
    logic [7:0] level;
    logic [7:0] goal;
    logic       last;
  } valve_report_t;

  valve_report_t valve_reports_q[$];

  logic [7:0]  rise_amt, fall_amt;
  logic [15:0] period_ms;
  logic [2:0]  anim_sel;
  logic        backward;
  logic [1:0]  gate_mode;

  logic        jet_open[13];
  logic [7:0]  jet_height[13];
  logic [7:0]  jet_target[13];
  logic [12:0] armed_mask;
  logic [3:0]  row_pos;
  logic [15:0] ms_count;

  logic [12:0] anim_rows[7][13];

  initial begin
    anim_rows[0] = '{13'h1555, 13'h0AAA, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    anim_rows[1] = '{13'h19B3, 13'h064C, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    anim_rows[2] = '{13'h1C07, 13'h03F8, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    anim_rows[3] = '{13'h1E0F, 13'h01F0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    anim_rows[4] = '{13'h0001, 13'h0002, 13'h0004, 13'h0008, 13'h0010, 13'h0020, 13'h0040,
                     13'h0080, 13'h0100, 13'h0200, 13'h0400, 13'h0800, 13'h1000};
    anim_rows[5] = '{13'h0003, 13'h000C, 13'h0030, 13'h00C8, 13'h0300, 13'h0C00, 13'h1001,
                     13'h0006, 13'h0018, 13'h0060, 13'h0180, 13'h0600, 13'h1800};
    anim_rows[6] = '{13'h1001, 13'h0802, 13'h0404, 13'h0208, 13'h0110, 13'h00A0, 13'h0040,
                     13'h00A0, 13'h0110, 13'h0208, 13'h0404, 13'h0802, 13'h1001};
  end

  function automatic logic launch_allowed(input logic bass, input logic vol);
    if (gate_mode == GATE_BASS && !bass) return 1'b0;
    if (gate_mode == GATE_VOLUME && !vol) return 1'b0;
    if (gate_mode == GATE_EITHER && !(bass || vol)) return 1'b0;
    for (int v = 0; v < 13; v++) begin
      if (armed_mask[v] && (jet_open[v] || jet_height[v] > (jet_target[v] >> 1))) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_tick(input logic [63:0] d);
    logic [7:0] peak[7];
    logic [8:0] h;
    int steps, idx, band;
    valve_report_t r;
    for (int b = 0; b < 7; b++) peak[b] = d[2 + 8*b +: 8];
    if (ms_count != 16'hFFFF) ms_count = ms_count + 16'd1;
    if ((ms_count > period_ms || d[0] || d[1]) && launch_allowed(d[0], d[1])) begin
      for (int v = 0; v < 13; v++) begin
        if (armed_mask[v]) begin
          band = v >> 1;
          jet_open[v] = 1'b1;
          if (v % 2 == 0) jet_target[v] = peak[band];
          else jet_target[v] = 8'(({1'b0, peak[band]} + {1'b0, peak[band + 1]}) >> 1);
        end
      end
      if (anim_sel != ANIM_INVALID) begin
        steps = (anim_sel >= ANIM_ROT_ONE) ? 13 : 2;
        idx = row_pos;
        if (!backward) idx = (idx + 1 >= steps) ? 0 : idx + 1;
        else if (idx == 0 || idx - 1 >= steps) idx = steps - 1;
        else idx = idx - 1;
        row_pos = 4'(idx);
        armed_mask = anim_rows[anim_sel][idx];
      end
    end
    if (ms_count >= period_ms) begin
      for (int v = 0; v < 13; v++) begin
        h = {1'b0, jet_height[v]};
        if (jet_open[v]) begin
          h = h + rise_amt;
          if (h > 9'd255) h = 9'd255;
          if (h >= jet_target[v]) jet_open[v] = 1'b0;
        end else begin
          h = (h > fall_amt) ? h - fall_amt : 9'd0;
        end
        jet_height[v] = h[7:0];
        r.index = 4'(v);
        r.is_open = jet_open[v];
        r.level = jet_height[v];
        r.goal = jet_target[v];
        r.last = (v == 12);
        valve_reports_q.push_back(r);
      end
      ms_count = 16'd0;
    end
  endtask

  task automatic compare_report();
    valve_report_t e;
    if (valve_reports_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("Unexpected result transaction: tdata %h tlast %b",
                                     out_tdata, out_tlast);
      return;
    end
    e = valve_reports_q.pop_front();
    if (out_tdata[3:0] !== e.index || out_tdata[4] !== e.is_open ||
        out_tdata[12:5] !== e.level || out_tdata[20:13] !== e.goal || out_tlast !== e.last) begin
      fail_count++;
      if (fail_count <= 10)
        $display({"Mismatch: expected valve %0d open %b level %0d goal %0d last %b, ",
                  "got valve %0d open %b level %0d goal %0d last %b"},
                 e.index, e.is_open, e.level, e.goal, e.last, out_tdata[3:0], out_tdata[4],
                 out_tdata[12:5], out_tdata[20:13], out_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
      rise_amt = 8'd40;
      fall_amt = 8'd20;
      period_ms = 16'd100;
      anim_sel = 3'd0;
      backward = 1'b0;
      gate_mode = GATE_NONE;
      for (int v = 0; v < 13; v++) begin
        jet_open[v] = 1'b0;
        jet_height[v] = 8'd0;
        jet_target[v] = 8'd0;
      end
      armed_mask = 13'd0;
      row_pos = 4'd0;
      ms_count = 16'd0;
      valve_reports_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RISE:   rise_amt = cfg_data[7:0];
          REG_FALL:   fall_amt = cfg_data[7:0];
          REG_PERIOD: period_ms = cfg_data;
          REG_ANIM:   anim_sel = cfg_data[2:0];
          REG_BACK:   backward = cfg_data[0];
          REG_GATE:   gate_mode = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_tick(in_tdata);
      if (out_tvalid && out_tready) compare_report();
    end
    pending = valve_reports_q.size();
  end
endmodule

@@ test/tb_top.sv @@
// Testbench top that drives ticks and configuration into the jet valve pattern sequencer.
`timescale 1ns / 1ps
module tb_top;
  import jvps_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = 64'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = REG_RISE;
  logic [15:0] cfg_data = 16'd0;
  int          fail_count;
  int          pending;
  int          burst_left = 4;
  int          cycle_no = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          ready_mode = 0;

  jet_valve_pattern_sequencer i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tlast, .cfg_wr_en, .cfg_index, .cfg_data
  );

  tb_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tlast, .cfg_wr_en, .cfg_index, .cfg_data, .fail_count, .pending
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // The receiver switches between random ready manners and holds off once for a long stretch,
  // starting while a result waits and the sender is offering a transaction.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no % 32 == 0) ready_mode <= $urandom_range(0, 2);
    if (!hold_done && cycle_no >= 2000 && in_tvalid && out_tvalid) begin
      hold_done <= 1'b1;
      hold_left <= 500;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (ready_mode == 0) begin
      out_tready <= 1'b1;
    end else if (ready_mode == 1) begin
      out_tready <= $urandom_range(0, 1);
    end else begin
      out_tready <= ($urandom_range(0, 4) == 0);
    end
  end

  function automatic logic [63:0] pack_tick(input logic bass, input logic vol,
                                            input logic [55:0] peaks);
    return {6'd0, peaks, vol, bass};
  endfunction

  function automatic logic [55:0] random_peaks();
    return 56'({$urandom, $urandom});
  endfunction

  task automatic send_tick(input logic [63:0] d);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_random(input int count, input int beat_odds);
    for (int n = 0; n < count; n++)
      send_tick(pack_tick($urandom_range(0, beat_odds) == 0, $urandom_range(0, beat_odds) == 0,
                          random_peaks()));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_RISE, 16'd255);
    write_reg(REG_FALL, 16'd255);
    write_reg(REG_PERIOD, 16'd1);
    write_reg(REG_ANIM, 16'd0);
    write_reg(REG_BACK, 16'd0);
    write_reg(REG_GATE, 16'(GATE_NONE));
    end_writes();
    send_tick(pack_tick(1'b0, 1'b0, 56'd0));
    send_tick(pack_tick(1'b1, 1'b1, {7{8'hFF}}));
    send_tick(pack_tick(1'b1, 1'b0, 56'hAA55AA55AA55AA));
    send_tick(pack_tick(1'b0, 1'b1, 56'h55AA55AA55AA55));
    send_random(2, 1);
    drain();

    write_reg(REG_GATE, 16'(GATE_BASS));
    write_reg(REG_PERIOD, 16'd0);
    write_reg(REG_RISE, 16'd0);
    write_reg(REG_FALL, 16'd0);
    end_writes();
    send_tick(pack_tick(1'b0, 1'b0, random_peaks()));
    send_tick(pack_tick(1'b1, 1'b0, random_peaks()));
    send_tick(pack_tick(1'b0, 1'b1, random_peaks()));
    send_tick(pack_tick(1'b1, 1'b1, random_peaks()));
    drain();

    write_reg(REG_GATE, 16'(GATE_VOLUME));
    write_reg(REG_RISE, 16'd40);
    write_reg(REG_FALL, 16'd20);
    write_reg(REG_PERIOD, 16'd2);
    write_reg(REG_ANIM, 16'(ANIM_ROT_ONE));
    end_writes();
    for (int n = 0; n < 5; n++) send_tick(pack_tick(1'b0, 1'b1, random_peaks()));
    drain();

    // Backward from a row index beyond a two-row table.
    write_reg(REG_GATE, 16'(GATE_EITHER));
    write_reg(REG_ANIM, 16'd0);
    write_reg(REG_BACK, 16'd1);
    end_writes();
    send_random(3, 0);
    drain();

    write_reg(REG_ANIM, 16'(ANIM_INVALID));
    write_reg(REG_GATE, 16'(GATE_NONE));
    end_writes();
    send_random(3, 2);
    drain();

    write_reg(REG_PERIOD, 16'hFFFF);
    end_writes();
    send_random(5, 0);
    drain();

    for (int p = 0; p < 9; p++) begin
      write_reg(REG_RISE, (p == 0) ? 16'd0 : 16'($urandom_range(0, 255)));
      write_reg(REG_FALL, (p == 1) ? 16'd255 : 16'($urandom_range(0, 255)));
      write_reg(REG_PERIOD, ($urandom_range(0, 7) == 0) ? 16'd40 : 16'($urandom_range(0, 5)));
      write_reg(REG_ANIM, (p == 2) ? 16'd5 : 16'($urandom_range(0, 7)));
      write_reg(REG_BACK, 16'($urandom_range(0, 1)));
      write_reg(REG_GATE, 16'($urandom_range(0, 3)));
      end_writes();
      send_random(9, $urandom_range(1, 4));
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
